@@ hw/rtl/convex_hull_graham_scan_macros.svh @@
// Assertion macros for the hull block, used by its back end.
`ifndef CONVEX_HULL_GRAHAM_SCAN_MACROS_SVH
`define CONVEX_HULL_GRAHAM_SCAN_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CHS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/chs_pkg.sv @@
package chs_pkg;

    // Default build sizes.
    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 16;

    // Stack height at which the scan begins.
    localparam int SCAN_START = 2;

endpackage

@@ hw/rtl/chs_fifo.sv @@
module chs_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);

    logic [WIDTH-1:0] r_mem [0:1];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    logic do_push;
    logic do_pop;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ hw/rtl/chs_front.sv @@
module chs_front #(
    parameter int MAX_POINTS = chs_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = chs_pkg::COORD_BITS_DEF,
    localparam int AW = $clog2(MAX_POINTS + 1),
    localparam int EW = 3 * AW + 4 * COORD_BITS + 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [COORD_BITS-1:0] i_pt_x,
    input  logic signed [COORD_BITS-1:0] i_pt_y,
    input  logic                         i_set_end,
    input  logic                         i_q_full,
    input  logic                         i_done,
    output logic                         o_busy,
    output logic                         o_push,
    output logic [EW-1:0]                o_entry
);

    logic [AW-1:0]                r_cnt;
    logic [AW-1:0]                r_pidx;
    logic signed [COORD_BITS-1:0] r_px;
    logic signed [COORD_BITS-1:0] r_py;
    logic                         r_drop;
    logic                         r_wait;

    logic                         accept;
    logic                         keep;
    logic                         new_piv;
    logic [AW-1:0]                n_cnt;
    logic [AW-1:0]                n_pidx;
    logic signed [COORD_BITS-1:0] n_px;
    logic signed [COORD_BITS-1:0] n_py;
    logic                         n_drop;

    assign o_busy  = r_wait || i_q_full || !i_rst_n;
    assign accept  = i_start && !o_busy;
    assign keep    = (r_cnt < AW'(MAX_POINTS));
    assign new_piv = keep && ((r_cnt == '0) || (i_pt_y < r_py));

    always_comb begin
        n_cnt  = keep ? r_cnt + AW'(1) : r_cnt;
        n_pidx = new_piv ? r_cnt : r_pidx;
        n_px   = new_piv ? i_pt_x : r_px;
        n_py   = new_piv ? i_pt_y : r_py;
        n_drop = r_drop || !keep;
    end

    assign o_push  = accept;
    assign o_entry = {keep, r_cnt, i_pt_x, i_pt_y, i_set_end,
                      n_cnt, n_pidx, n_px, n_py, n_drop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_pidx <= '0;
            r_px   <= '0;
            r_py   <= '0;
            r_drop <= 1'b0;
            r_wait <= 1'b0;
        end else begin
            if (i_done) begin
                r_wait <= 1'b0;
            end
            if (accept) begin
                if (i_set_end) begin
                    r_cnt  <= '0;
                    r_pidx <= '0;
                    r_px   <= '0;
                    r_py   <= '0;
                    r_drop <= 1'b0;
                    r_wait <= 1'b1;
                end else begin
                    r_cnt  <= n_cnt;
                    r_pidx <= n_pidx;
                    r_px   <= n_px;
                    r_py   <= n_py;
                    r_drop <= n_drop;
                end
            end
        end
    end

endmodule

@@ hw/rtl/chs_orient.sv @@
module chs_orient #(
    parameter int COORD_BITS = chs_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_ox,
    input  logic signed [COORD_BITS-1:0] i_oy,
    input  logic signed [COORD_BITS-1:0] i_ax,
    input  logic signed [COORD_BITS-1:0] i_ay,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by,
    output logic                         o_valid,
    output logic                         o_turn_lt,
    output logic                         o_prec
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    logic              r_v1;
    logic              r_v2;
    logic signed [DW-1:0] r_dax;
    logic signed [DW-1:0] r_day;
    logic signed [DW-1:0] r_dbx;
    logic signed [DW-1:0] r_dby;
    logic signed [PW-1:0] r_l;
    logic signed [PW-1:0] r_r;
    logic [PW-1:0]        r_sax;
    logic [PW-1:0]        r_say;
    logic [PW-1:0]        r_sbx;
    logic [PW-1:0]        r_sby;
    logic                 r_ay0;
    logic                 r_by0;
    logic                 r_apos;
    logic                 r_aneg;
    logic                 r_bpos;
    logic                 r_bneg;

    logic [PW:0] da2;
    logic [PW:0] db2;
    logic        tie_prec;

    assign da2 = {1'b0, r_sax} + {1'b0, r_say};
    assign db2 = {1'b0, r_sbx} + {1'b0, r_sby};

    // Collinear tie: on the pivot's row, angle zero beats angle pi; else nearer first.
    always_comb begin
        if (r_ay0 && r_by0 && r_apos && r_bneg) begin
            tie_prec = 1'b1;
        end else if (r_ay0 && r_by0 && r_aneg && r_bpos) begin
            tie_prec = 1'b0;
        end else begin
            tie_prec = (da2 < db2);
        end
    end

    always_ff @(posedge i_clk) begin
        r_dax <= DW'(i_ax) - DW'(i_ox);
        r_day <= DW'(i_ay) - DW'(i_oy);
        r_dbx <= DW'(i_bx) - DW'(i_ox);
        r_dby <= DW'(i_by) - DW'(i_oy);

        r_l   <= r_dax * r_dby;
        r_r   <= r_dbx * r_day;
        r_sax <= PW'(r_dax * r_dax);
        r_say <= PW'(r_day * r_day);
        r_sbx <= PW'(r_dbx * r_dbx);
        r_sby <= PW'(r_dby * r_dby);
        r_ay0  <= (r_day == '0);
        r_by0  <= (r_dby == '0);
        r_apos <= (r_dax > 0);
        r_aneg <= (r_dax < 0);
        r_bpos <= (r_dbx > 0);
        r_bneg <= (r_dbx < 0);

        o_turn_lt <= (r_l < r_r);
        o_prec    <= (r_l > r_r) || ((r_l == r_r) && tie_prec);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            o_valid <= r_v2;
        end
    end

endmodule

@@ hw/rtl/chs_back.sv @@
`include "convex_hull_graham_scan_macros.svh"

module chs_back #(
    parameter int MAX_POINTS = chs_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = chs_pkg::COORD_BITS_DEF,
    localparam int AW = $clog2(MAX_POINTS + 1),
    localparam int EW = 3 * AW + 4 * COORD_BITS + 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [EW-1:0]                i_entry,
    input  logic                         i_empty,
    output logic                         o_pop,
    output logic                         o_done,
    output logic                         o_valid,
    output logic signed [COORD_BITS-1:0] o_hull_x,
    output logic signed [COORD_BITS-1:0] o_hull_y,
    output logic [AW-1:0]                o_hull_count,
    output logic                         o_hull_last,
    output logic                         o_overflow
);

    localparam int CB    = COORD_BITS;
    localparam int PT_W  = 2 * CB;
    localparam int DEPTH = MAX_POINTS + 1;
    localparam int CW    = AW + 1;

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_SW_RD   = 5'd1;
    localparam logic [4:0] ST_SW_WR1  = 5'd2;
    localparam logic [4:0] ST_SW_WR0  = 5'd3;
    localparam logic [4:0] ST_SW_WRN  = 5'd4;
    localparam logic [4:0] ST_SO_LD   = 5'd5;
    localparam logic [4:0] ST_SO_LT   = 5'd6;
    localparam logic [4:0] ST_SO_RD   = 5'd7;
    localparam logic [4:0] ST_SO_CMP  = 5'd8;
    localparam logic [4:0] ST_SO_WT   = 5'd9;
    localparam logic [4:0] ST_SO_PUT  = 5'd10;
    localparam logic [4:0] ST_SC_LD   = 5'd11;
    localparam logic [4:0] ST_SC_LT   = 5'd12;
    localparam logic [4:0] ST_SC_RD   = 5'd13;
    localparam logic [4:0] ST_SC_CMP  = 5'd14;
    localparam logic [4:0] ST_SC_WT   = 5'd15;
    localparam logic [4:0] ST_SC_PUSH = 5'd16;
    localparam logic [4:0] ST_SC_SW1  = 5'd17;
    localparam logic [4:0] ST_SC_SW2  = 5'd18;
    localparam logic [4:0] ST_EMIT    = 5'd19;
    localparam logic [4:0] ST_DONE    = 5'd20;

    // Queue entry fields.
    logic          e_wr;
    logic [AW-1:0] e_addr;
    logic [CB-1:0] e_x;
    logic [CB-1:0] e_y;
    logic          e_end;
    logic [AW-1:0] e_n;
    logic [AW-1:0] e_pidx;
    logic [CB-1:0] e_px;
    logic [CB-1:0] e_py;
    logic          e_drop;

    assign {e_wr, e_addr, e_x, e_y, e_end, e_n, e_pidx, e_px, e_py, e_drop} = i_entry;

    logic [PT_W-1:0] r_mem [0:DEPTH-1];
    logic [PT_W-1:0] r_rd_a;
    logic [PT_W-1:0] r_rd_b;

    logic [4:0]      r_state, n_state;
    logic [AW-1:0]   r_n, n_n;
    logic [AW-1:0]   r_pidx, n_pidx;
    logic [PT_W-1:0] r_piv, n_piv;
    logic            r_drop, n_drop;
    logic [CW-1:0]   r_i, n_i;
    logic [AW-1:0]   r_j, n_j;
    logic [AW-1:0]   r_top, n_top;
    logic [PT_W-1:0] r_t, n_t;
    logic [PT_W-1:0] r_mv, n_mv;
    logic [PT_W-1:0] r_cur, n_cur;
    logic [CW-1:0]   r_k, n_k;
    logic [AW-1:0]   r_cnt, n_cnt;
    logic            r_out_vld;
    logic            r_out_last;

    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic [PT_W-1:0] mem_wd;
    logic [AW-1:0]   ra;
    logic [AW-1:0]   rb;
    logic            u_vld;
    logic            issue;
    logic            issue_last;

    logic [PT_W-1:0] u_o;
    logic [PT_W-1:0] u_a;
    logic [PT_W-1:0] u_b;
    logic            u_ovld;
    logic            u_lt;
    logic            u_prec;

    always_comb begin
        if (r_state == ST_SO_CMP) begin
            u_o = r_piv;
            u_a = r_t;
            u_b = r_rd_a;
        end else begin
            u_o = r_rd_a;
            u_a = r_rd_b;
            u_b = r_cur;
        end
    end

    chs_orient #(
        .COORD_BITS(COORD_BITS)
    ) u_orient (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (u_vld),
        .i_ox      (u_o[PT_W-1:CB]),
        .i_oy      (u_o[CB-1:0]),
        .i_ax      (u_a[PT_W-1:CB]),
        .i_ay      (u_a[CB-1:0]),
        .i_bx      (u_b[PT_W-1:CB]),
        .i_by      (u_b[CB-1:0]),
        .o_valid   (u_ovld),
        .o_turn_lt (u_lt),
        .o_prec    (u_prec)
    );

    always_comb begin
        n_state    = r_state;
        n_n        = r_n;
        n_pidx     = r_pidx;
        n_piv      = r_piv;
        n_drop     = r_drop;
        n_i        = r_i;
        n_j        = r_j;
        n_top      = r_top;
        n_t        = r_t;
        n_mv       = r_mv;
        n_cur      = r_cur;
        n_k        = r_k;
        n_cnt      = r_cnt;
        mem_we     = 1'b0;
        mem_wa     = '0;
        mem_wd     = '0;
        ra         = '0;
        rb         = '0;
        u_vld      = 1'b0;
        issue      = 1'b0;
        issue_last = 1'b0;
        o_pop      = 1'b0;
        o_done     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (e_wr) begin
                        mem_we = 1'b1;
                        mem_wa = e_addr;
                        mem_wd = {e_x, e_y};
                    end
                    if (e_end) begin
                        n_n    = e_n;
                        n_pidx = e_pidx;
                        n_piv  = {e_px, e_py};
                        n_drop = e_drop;
                        n_k    = '0;
                        if (e_n <= AW'(2)) begin
                            n_cnt   = e_n;
                            n_state = ST_EMIT;
                        end else begin
                            n_state = ST_SW_RD;
                        end
                    end
                end
            end
            ST_SW_RD: begin
                ra      = '0;
                n_state = ST_SW_WR1;
            end
            ST_SW_WR1: begin
                mem_we  = 1'b1;
                mem_wa  = r_pidx;
                mem_wd  = r_rd_a;
                n_state = ST_SW_WR0;
            end
            ST_SW_WR0: begin
                mem_we  = 1'b1;
                mem_wa  = '0;
                mem_wd  = r_piv;
                n_state = ST_SW_WRN;
            end
            ST_SW_WRN: begin
                mem_we  = 1'b1;
                mem_wa  = r_n;
                mem_wd  = r_piv;
                n_i     = CW'(2);
                n_state = ST_SO_LD;
            end
            ST_SO_LD: begin
                if (r_i == {1'b0, r_n}) begin
                    n_top   = AW'(chs_pkg::SCAN_START);
                    n_i     = CW'(chs_pkg::SCAN_START + 1);
                    n_state = ST_SC_LD;
                end else begin
                    ra      = r_i[AW-1:0];
                    n_j     = r_i[AW-1:0];
                    n_state = ST_SO_LT;
                end
            end
            ST_SO_LT: begin
                n_t     = r_rd_a;
                n_state = ST_SO_RD;
            end
            ST_SO_RD: begin
                if (r_j > AW'(1)) begin
                    ra      = r_j - AW'(1);
                    n_state = ST_SO_CMP;
                end else begin
                    n_state = ST_SO_PUT;
                end
            end
            ST_SO_CMP: begin
                u_vld   = 1'b1;
                n_mv    = r_rd_a;
                n_state = ST_SO_WT;
            end
            ST_SO_WT: begin
                if (u_ovld) begin
                    if (u_prec) begin
                        mem_we  = 1'b1;
                        mem_wa  = r_j;
                        mem_wd  = r_mv;
                        n_j     = r_j - AW'(1);
                        n_state = ST_SO_RD;
                    end else begin
                        n_state = ST_SO_PUT;
                    end
                end
            end
            ST_SO_PUT: begin
                mem_we  = 1'b1;
                mem_wa  = r_j;
                mem_wd  = r_t;
                n_i     = r_i + CW'(1);
                n_state = ST_SO_LD;
            end
            ST_SC_LD: begin
                if (r_i > {1'b0, r_n}) begin
                    n_cnt   = r_top;
                    n_k     = '0;
                    n_state = ST_EMIT;
                end else begin
                    ra      = r_i[AW-1:0];
                    n_state = ST_SC_LT;
                end
            end
            ST_SC_LT: begin
                n_cur   = r_rd_a;
                n_state = ST_SC_RD;
            end
            ST_SC_RD: begin
                if (r_top > AW'(1)) begin
                    ra      = r_top - AW'(1);
                    rb      = r_top;
                    n_state = ST_SC_CMP;
                end else begin
                    n_state = ST_SC_PUSH;
                end
            end
            ST_SC_CMP: begin
                u_vld   = 1'b1;
                n_state = ST_SC_WT;
            end
            ST_SC_WT: begin
                if (u_ovld) begin
                    if (u_lt) begin
                        n_top   = r_top - AW'(1);
                        n_state = ST_SC_RD;
                    end else begin
                        n_state = ST_SC_PUSH;
                    end
                end
            end
            ST_SC_PUSH: begin
                ra      = r_top + AW'(1);
                n_top   = r_top + AW'(1);
                n_state = ST_SC_SW1;
            end
            ST_SC_SW1: begin
                mem_we  = 1'b1;
                mem_wa  = r_i[AW-1:0];
                mem_wd  = r_rd_a;
                n_state = ST_SC_SW2;
            end
            ST_SC_SW2: begin
                mem_we  = 1'b1;
                mem_wa  = r_top;
                mem_wd  = r_cur;
                n_i     = r_i + CW'(1);
                n_state = ST_SC_LD;
            end
            ST_EMIT: begin
                if (r_k < {1'b0, r_cnt}) begin
                    ra         = r_k[AW-1:0];
                    issue      = 1'b1;
                    issue_last = (r_k + CW'(1) == {1'b0, r_cnt});
                    n_k        = r_k + CW'(1);
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_a <= r_mem[ra];
        r_rd_b <= r_mem[rb];
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_pidx <= n_pidx;
        r_piv  <= n_piv;
        r_drop <= n_drop;
        r_i    <= n_i;
        r_j    <= n_j;
        r_top  <= n_top;
        r_t    <= n_t;
        r_mv   <= n_mv;
        r_cur  <= n_cur;
        r_k    <= n_k;
        r_cnt  <= n_cnt;
        r_out_last <= issue_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= issue;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_hull_x     = r_rd_a[PT_W-1:CB];
    assign o_hull_y     = r_rd_a[CB-1:0];
    assign o_hull_count = r_cnt;
    assign o_hull_last  = r_out_last;
    assign o_overflow   = r_drop;

    `CHS_ASSERT_NEXT(a_last_ends_burst, i_clk, i_rst_n, r_out_vld && r_out_last, !r_out_vld, "result after the final vertex")
    `CHS_ASSERT_NOW(a_top_in_range, i_clk, i_rst_n, r_state == ST_SC_RD || r_state == ST_SC_PUSH, r_top < r_n, "stack top beyond point count")
    `CHS_ASSERT_NOW(a_sort_hole, i_clk, i_rst_n, r_state == ST_SO_RD || r_state == ST_SO_PUT, r_j <= r_i[AW-1:0] && r_j >= AW'(1), "insertion slot out of range")
    `CHS_ASSERT_NOW(a_emit_count, i_clk, i_rst_n, r_out_vld, r_cnt != '0, "vertex emitted for empty hull")

endmodule

@@ hw/rtl/convex_hull_graham_scan.sv @@
// Loading: a point is taken in every cycle while busy is low.
// After the point that closes a set, busy stays high while the hull is built: the pivot is
// placed first, then each later point is insertion-sorted by angle, and then the points
// are scanned with turn tests, each test waiting on the orientation unit.
// Vertices leave one per cycle; busy drops once the last vertex has left.
// Results cannot stall. Reset (synchronous, active low) empties the queue and returns to loading.
module convex_hull_graham_scan #(
    parameter int MAX_POINTS = chs_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = chs_pkg::COORD_BITS_DEF,
    localparam int AW = $clog2(MAX_POINTS + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_pt_x,
    input  logic signed [COORD_BITS-1:0] i_pt_y,
    input  logic                         i_set_end,
    output logic                         o_valid,
    output logic signed [COORD_BITS-1:0] o_hull_x,
    output logic signed [COORD_BITS-1:0] o_hull_y,
    output logic [AW-1:0]                o_hull_count,
    output logic                         o_hull_last,
    output logic                         o_overflow
);

    // One queue entry per accepted request: an optional point write and, on the
    // last point, the set summary (count, pivot slot, pivot point, drop flag).
    localparam int EW = 3 * AW + 4 * COORD_BITS + 3;

    logic          push;
    logic [EW-1:0] push_entry;
    logic          q_full;
    logic          q_empty;
    logic          pop;
    logic [EW-1:0] head_entry;
    logic          done;

    // The front end tracks the count, the lowest-y pivot and dropped points.
    chs_front #(
        .MAX_POINTS(MAX_POINTS),
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_pt_x    (i_pt_x),
        .i_pt_y    (i_pt_y),
        .i_set_end (i_set_end),
        .i_q_full  (q_full),
        .i_done    (done),
        .o_busy    (busy),
        .o_push    (push),
        .o_entry   (push_entry)
    );

    // A two-entry queue lets the front end keep loading while the back end writes.
    chs_fifo #(
        .WIDTH(EW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .i_pop   (pop),
        .o_data  (head_entry),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // The back end owns the point memory, sorts, scans and emits the hull.
    chs_back #(
        .MAX_POINTS(MAX_POINTS),
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_entry      (head_entry),
        .i_empty      (q_empty),
        .o_pop        (pop),
        .o_done       (done),
        .o_valid      (o_valid),
        .o_hull_x     (o_hull_x),
        .o_hull_y     (o_hull_y),
        .o_hull_count (o_hull_count),
        .o_hull_last  (o_hull_last),
        .o_overflow   (o_overflow)
    );

endmodule

@@ tb/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The block holds at most this many points per set; a set of one or two
    // points is echoed, anything larger goes through the sort and the scan.
    localparam int CAP = chs_pkg::MAX_POINTS_DEF;
    localparam int CB  = chs_pkg::COORD_BITS_DEF;
    localparam int AW  = $clog2(CAP + 1);

    // Cycles without any request or result accepted before the run is abandoned.
    // The limit leaves a wide margin for the slowest set (a full store sorted in
    // reverse order).
    localparam int STALL_LIMIT = 300000;

    // Cycles to wait after the last expected vertex, in case stray output follows.
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic                 last;
    } point_req_t;

    typedef struct {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic [AW-1:0]        count;
        logic                 last;
        logic                 ovf;
    } vertex_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic signed [CB-1:0] i_pt_x = '0;
    logic signed [CB-1:0] i_pt_y = '0;
    logic                 i_set_end = 1'b0;
    logic                 o_valid;
    logic signed [CB-1:0] o_hull_x;
    logic signed [CB-1:0] o_hull_y;
    logic [AW-1:0]        o_hull_count;
    logic                 o_hull_last;
    logic                 o_overflow;

    convex_hull_graham_scan dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_pt_x       (i_pt_x),
        .i_pt_y       (i_pt_y),
        .i_set_end    (i_set_end),
        .o_valid      (o_valid),
        .o_hull_x     (o_hull_x),
        .o_hull_y     (o_hull_y),
        .o_hull_count (o_hull_count),
        .o_hull_last  (o_hull_last),
        .o_overflow   (o_overflow)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Points waiting to be sent; the head stays in the queue until accepted.
    point_req_t point_q[$];
    // Hull vertices predicted but not yet seen on the output.
    vertex_t    vertex_q[$];

    int err_count = 0;
    int sent_count = 0;
    int stall_cycles = 0;

    // Shadow state of the hull block for the set being loaded.
    longint held_x[0:CAP];
    longint held_y[0:CAP];
    int     held_total = 0;
    int     pivot_slot = 0;
    longint pivot_x = 0;
    longint pivot_y = 0;
    bit     points_dropped = 1'b0;

    // Sign of the cross product (b - a) x (c - a), computed exactly.
    function automatic int orient(longint ax, longint ay, longint bx, longint by,
                                  longint cx, longint cy);
        longint l;
        longint r;
        l = (bx - ax) * (cy - ay);
        r = (cx - ax) * (by - ay);
        return (l > r) ? 1 : ((l < r) ? -1 : 0);
    endfunction

    // True when point a comes strictly before point b in angular order around
    // the pivot. Collinear points order by distance; on the pivot's own row the
    // points to the right come before those to the left.
    function automatic bit angle_before(longint ax, longint ay, longint bx, longint by);
        int     s;
        longint dax;
        longint day;
        longint dbx;
        longint dby;
        s = orient(pivot_x, pivot_y, ax, ay, bx, by);
        dax = ax - pivot_x;
        day = ay - pivot_y;
        dbx = bx - pivot_x;
        dby = by - pivot_y;
        if (s > 0) return 1'b1;
        if (s < 0) return 1'b0;
        if (day == 0 && dby == 0) begin
            if (dax > 0 && dbx < 0) return 1'b1;
            if (dax < 0 && dbx > 0) return 1'b0;
        end
        return (dax * dax + day * day) < (dbx * dbx + dby * dby);
    endfunction

    task automatic push_vertex(longint x, longint y, int k, int count);
        vertex_t v;
        v.x = x[CB-1:0];
        v.y = y[CB-1:0];
        v.count = count[AW-1:0];
        v.last = (k + 1 == count);
        v.ovf = points_dropped;
        vertex_q.push_back(v);
    endtask

    // Takes one accepted point. When it closes a set, the hull is built here
    // and its vertices are queued in the order the block must emit them.
    task automatic absorb_point(point_req_t p);
        longint wx[0:CAP];
        longint wy[0:CAP];
        longint tx;
        longint ty;
        int     n;
        int     j;
        int     top;
        if (held_total < CAP) begin
            held_x[held_total] = p.x;
            held_y[held_total] = p.y;
            if (held_total == 0 || p.y < pivot_y) begin
                pivot_slot = held_total;
                pivot_x = p.x;
                pivot_y = p.y;
            end
            held_total++;
        end else begin
            // A full store drops the point, even when it is the one closing the set.
            points_dropped = 1'b1;
        end
        if (!p.last) return;

        n = held_total;
        if (n <= 2) begin
            for (int k = 0; k < n; k++) push_vertex(held_x[k], held_y[k], k, n);
        end else begin
            for (int i = 0; i < n; i++) begin
                wx[i] = held_x[i];
                wy[i] = held_y[i];
            end
            // The pivot trades places with the first point held.
            wx[pivot_slot] = held_x[0];
            wy[pivot_slot] = held_y[0];
            wx[0] = pivot_x;
            wy[0] = pivot_y;
            // Stable insertion sort of everything after the pivot.
            for (int i = 2; i < n; i++) begin
                tx = wx[i];
                ty = wy[i];
                j = i;
                while (j > 1 && angle_before(tx, ty, wx[j-1], wy[j-1])) begin
                    wx[j] = wx[j-1];
                    wy[j] = wy[j-1];
                    j--;
                end
                wx[j] = tx;
                wy[j] = ty;
            end
            // The pivot closes the sequence as a sentinel for the scan.
            wx[n] = pivot_x;
            wy[n] = pivot_y;
            // Pop only on a strictly clockwise turn and never below two entries,
            // so collinear points stay on the hull.
            top = chs_pkg::SCAN_START;
            for (int i = 3; i <= n; i++) begin
                while (top > 1 && orient(wx[top-1], wy[top-1], wx[top], wy[top],
                                         wx[i], wy[i]) < 0)
                    top--;
                top++;
                tx = wx[top];
                ty = wy[top];
                wx[top] = wx[i];
                wy[top] = wy[i];
                wx[i] = tx;
                wy[i] = ty;
            end
            for (int k = 0; k < top; k++) push_vertex(wx[k], wy[k], k, top);
        end
        held_total = 0;
        pivot_slot = 0;
        pivot_x = 0;
        pivot_y = 0;
        points_dropped = 1'b0;
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    task automatic add_point(int x, int y, bit last);
        point_req_t p;
        p.x = x[CB-1:0];
        p.y = y[CB-1:0];
        p.last = last;
        point_q.push_back(p);
    endtask

    // Random coordinate: full range most often, otherwise a tiny grid that
    // produces duplicates and collinear runs, or one of the range extremes or zero.
    function automatic int pick_coord(int mode);
        int e;
        case (mode)
            0: begin
                return $signed(16'($urandom()));
            end
            1: begin
                return $urandom_range(0, 8) - 4;
            end
            default: begin
                e = $urandom_range(0, 2);
                return (e == 0) ? -32768 : ((e == 1) ? 32767 : 0);
            end
        endcase
    endfunction

    task automatic add_random_set(int n);
        int mode;
        mode = $urandom_range(0, 9);
        mode = (mode < 5) ? 0 : ((mode < 9) ? 1 : 2);
        for (int i = 0; i < n; i++) add_point(pick_coord(mode), pick_coord(mode), i == n - 1);
    endtask

    // Driver: a request is accepted at an edge where start is high and busy is
    // low. The head of the queue is held on the ports until then; between
    // requests the driver sometimes idles, except for a stretch in the middle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                absorb_point(point_q.pop_front());
                sent_count++;
            end
            if (start && busy) begin
                // Hold the current request.
            end else if (point_q.size() > 0 &&
                         !((sent_count < 110 || sent_count >= 200) &&
                           $urandom_range(0, 99) < 26)) begin
                i_pt_x <= point_q[0].x;
                i_pt_y <= point_q[0].y;
                i_set_end <= point_q[0].last;
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every strobed vertex must match the oldest predicted one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (vertex_q.size() == 0) begin
                $display("unexpected vertex (%0d, %0d) at %0t", o_hull_x, o_hull_y, $realtime);
                err_count++;
            end else begin
                if (o_hull_x !== vertex_q[0].x)
                    report_mismatch("hull_x", o_hull_x, vertex_q[0].x);
                if (o_hull_y !== vertex_q[0].y)
                    report_mismatch("hull_y", o_hull_y, vertex_q[0].y);
                if (o_hull_count !== vertex_q[0].count)
                    report_mismatch("hull_count", o_hull_count, vertex_q[0].count);
                if (o_hull_last !== vertex_q[0].last)
                    report_mismatch("hull_last", o_hull_last, vertex_q[0].last);
                if (o_overflow !== vertex_q[0].ovf)
                    report_mismatch("overflow", o_overflow, vertex_q[0].ovf);
                void'(vertex_q.pop_front());
            end
        end
    end

    // Watchdog on progress: any accepted request or result restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int total;
        int r;
        int n;

        // Directed sets. A single point and a pair are echoed as they came.
        add_point(-32768, -32768, 1'b1);
        add_point(32767, 32767, 1'b0);
        add_point(0, -1, 1'b1);
        // Triangle spanning the whole coordinate range.
        add_point(-32768, 32767, 1'b0);
        add_point(32767, -32768, 1'b0);
        add_point(-32768, -32768, 1'b1);
        // Pivot tie on the lowest row, points on both sides of it on that row,
        // a copy of the pivot, and a collinear run along a diagonal.
        add_point(0, 0, 1'b0);
        add_point(5, 0, 1'b0);
        add_point(-5, 0, 1'b0);
        add_point(0, 0, 1'b0);
        add_point(2, 2, 1'b0);
        add_point(4, 4, 1'b0);
        add_point(6, 6, 1'b0);
        add_point(0, 6, 1'b0);
        add_point(1, 3, 1'b1);
        // Square with the corners out of order and a point on one edge.
        add_point(10, 10, 1'b0);
        add_point(-10, -10, 1'b0);
        add_point(10, -10, 1'b0);
        add_point(-10, 10, 1'b0);
        add_point(0, -10, 1'b1);
        // All points on one line.
        add_point(3, 3, 1'b0);
        add_point(1, 1, 1'b0);
        add_point(2, 2, 1'b1);

        // One set past capacity, so that the closing point itself is dropped.
        for (int i = 0; i < CAP + 3; i++)
            add_point(pick_coord(0), pick_coord(0), i == CAP + 2);

        total = point_q.size();
        while (total < 310) begin
            r = $urandom_range(0, 99);
            if (r < 3) n = $urandom_range(CAP + 1, CAP + 4);
            else if (r < 7) n = $urandom_range(30, CAP);
            else if (r < 20) n = $urandom_range(1, 2);
            else n = $urandom_range(3, 10);
            add_random_set(n);
            total += n;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (point_q.size() != 0 || vertex_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ convex_hull_graham_scan.f @@
+incdir+hw/rtl
hw/rtl/chs_pkg.sv
hw/rtl/chs_fifo.sv
hw/rtl/chs_front.sv
hw/rtl/chs_orient.sv
hw/rtl/chs_back.sv
hw/rtl/convex_hull_graham_scan.sv
tb/tb.sv
